[hw/rtl/svhp_pkg.sv]
// ----------------------------------------------------------------------------
// svhp_pkg - speed vector heading projection package
// Widths, fixed-point constants, the CORDIC arctangent table and word types.
// ----------------------------------------------------------------------------
package svhp_pkg;

  localparam int SPEED_W         = 16;
  localparam int HEAD_W          = 14;
  localparam int YAW_W           = 16;
  localparam int GAIN_W          = 16;
  localparam int FWD_W           = 20;
  localparam int MAX_STAGES      = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  // vector datapath: Q4.12 plus 16 extra fraction bits, sign, fold and growth
  localparam int VW     = 36;
  // angle datapath: 32-bit binary angle plus one guard bit
  localparam int ZW     = 33;
  localparam int ATAN_W = 30;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd256;
  localparam logic [29:0]       INV_GAIN  = 30'd652032874;
  localparam logic [17:0]       YAW_MUL   = 18'd83443;
  localparam logic [20:0]       HEAD_MUL  = 21'd182;
  localparam logic [20:0]       HEAD_RND  = 21'd2002;
  localparam logic [12:0]       DIV_4095  = 13'd4095;
  localparam logic [31:0]       EIGHTH_TURN = 32'h2000_0000;

  typedef struct packed {
    logic signed [SPEED_W-1:0] turn;
    logic                      spin;
    logic                      down;
  } side_t;

  typedef struct packed {
    logic signed [FWD_W-1:0]   forward_speed;
    logic signed [SPEED_W-1:0] turn_speed;
    logic                      down_slope;
  } out_word_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic [ATAN_W-1:0] atan_bam(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    unique case (idx)
      5'd0:    r = 30'h2000_0000;
      5'd1:    r = 30'h12E4_051E;
      5'd2:    r = 30'h09FB_385B;
      5'd3:    r = 30'h0511_11D4;
      5'd4:    r = 30'h028B_0D43;
      5'd5:    r = 30'h0145_D7E1;
      5'd6:    r = 30'h00A2_F61E;
      5'd7:    r = 30'h0051_7C55;
      5'd8:    r = 30'h0028_BE53;
      5'd9:    r = 30'h0014_5F2F;
      5'd10:   r = 30'h000A_2F98;
      5'd11:   r = 30'h0005_17CC;
      5'd12:   r = 30'h0002_8BE6;
      5'd13:   r = 30'h0001_45F3;
      5'd14:   r = 30'h0000_A2FA;
      5'd15:   r = 30'h0000_517D;
      5'd16:   r = 30'h0000_28BE;
      5'd17:   r = 30'h0000_145F;
      5'd18:   r = 30'h0000_0A30;
      5'd19:   r = 30'h0000_0518;
      5'd20:   r = 30'h0000_028C;
      5'd21:   r = 30'h0000_0146;
      5'd22:   r = 30'h0000_00A3;
      5'd23:   r = 30'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/svhp_if.sv]
// ----------------------------------------------------------------------------
// svhp_if - channel interfaces
// Input sample, result and gain write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface svhp_in_if import svhp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_x;
  logic signed [SPEED_W-1:0] speed_y;
  logic signed [SPEED_W-1:0] speed_turn;
  logic signed [HEAD_W-1:0]  chassis_heading;
  logic signed [YAW_W-1:0]   yaw_rate;
  logic                      spin_mode;
  logic                      ascent_mode;

  modport source (output valid, speed_x, speed_y, speed_turn, chassis_heading,
                  yaw_rate, spin_mode, ascent_mode, input ready);
  modport sink   (input valid, speed_x, speed_y, speed_turn, chassis_heading,
                  yaw_rate, spin_mode, ascent_mode, output ready);
endinterface

interface svhp_out_if import svhp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FWD_W-1:0]   forward_speed;
  logic signed [SPEED_W-1:0] turn_speed;
  logic                      down_slope;

  modport source (output valid, forward_speed, turn_speed, down_slope, input ready);
  modport sink   (input valid, forward_speed, turn_speed, down_slope, output ready);
endinterface

interface svhp_cfg_if import svhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] spin_move_gain;

  modport source (output valid, spin_move_gain, input ready);
  modport sink   (input valid, spin_move_gain, output ready);
endinterface

[hw/rtl/speed_vector_heading_projection.sv]
// ----------------------------------------------------------------------------
// speed_vector_heading_projection - CORDIC heading projection
// Projects the commanded speed vector onto the chassis heading.
// ----------------------------------------------------------------------------
// One sample is taken per clock while din.ready is high, and one result word
// leaves per clock while dout.ready is high. Four stages build the binary
// angle and fold it into the right half plane; then come one stage per CORDIC
// iteration, two stages for the split gain-correction multiply, one for the
// spin gain multiply, and the output register. A two-word output buffer holds
// results while the sink stalls; din.ready drops only when both words are
// occupied. The gain register is written through cfg at any time, taking
// effect for samples that reach the gain stage after the write.
module speed_vector_heading_projection
  import svhp_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  svhp_cfg_if.sink     cfg,
  svhp_in_if.sink      din,
  svhp_out_if.source   dout
);

  localparam int N = CORDIC_STAGES;

  logic              en;
  logic [1:0]        cnt;
  logic [1:0]        cnt_next;
  logic              push;
  logic              pop;
  logic [GAIN_W-1:0] gain;

  // ---------------- gain register ----------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RST;
    end else if (cfg.valid) begin
      gain <= cfg.spin_move_gain;
    end
  end

  // ---------------- stage 1: |heading|, yaw product ----------------
  logic                      s1_vld;
  logic [HEAD_W-1:0]         s1_a;
  logic                      s1_neg;
  logic signed [33:0]        s1_yprod;
  logic signed [SPEED_W-1:0] s1_sx;
  logic signed [SPEED_W-1:0] s1_sy;
  side_t                     s1_side;

  // ---------------- stage 2: heading * 182, spin offset ----------------
  logic                      s2_vld;
  logic [20:0]               s2_b;
  logic                      s2_neg;
  logic [31:0]               s2_off;
  logic signed [SPEED_W-1:0] s2_sx;
  logic signed [SPEED_W-1:0] s2_sy;
  side_t                     s2_side;

  // ---------------- stage 3: rounded heading angle ----------------
  logic                      s3_vld;
  logic [31:0]               s3_hb;
  logic [31:0]               s3_off;
  logic signed [SPEED_W-1:0] s3_sx;
  logic signed [SPEED_W-1:0] s3_sy;
  side_t                     s3_side;

  logic [20:0] s3_m;
  logic [12:0] s3_t;
  logic [8:0]  s3_q;
  logic [31:0] s3_hab;

  // b/4095 rounded: 2^12 = 1 mod 4095, so one compare fixes the quotient
  always_comb begin
    s3_m   = s2_b + HEAD_RND;
    s3_t   = {4'b0, s3_m[20:12]} + {1'b0, s3_m[11:0]};
    s3_q   = s3_m[20:12] + {8'b0, (s3_t >= DIV_4095)};
    s3_hab = 32'({s2_b, 12'b0}) + {11'b0, s2_b} + {23'b0, s3_q};
  end

  // ---------------- stage 4: angle sum and quadrant fold ----------------
  logic [31:0]          s4_ang;
  logic                 s4_fold;
  logic signed [VW-1:0] s4_vx;
  logic signed [VW-1:0] s4_vy;

  always_comb begin
    s4_ang  = s3_hb + (s3_side.spin ? s3_off : 32'b0);
    s4_fold = s4_ang[31] ^ s4_ang[30];
    s4_vx   = {{(VW-SPEED_W-16){s3_sx[SPEED_W-1]}}, s3_sx, 16'b0};
    s4_vy   = {{(VW-SPEED_W-16){s3_sy[SPEED_W-1]}}, s3_sy, 16'b0};
  end

  // CORDIC pipeline, index 0 is the folded input
  logic                 cv    [N+1];
  logic signed [VW-1:0] cx    [N+1];
  logic signed [VW-1:0] cy    [N+1];
  logic signed [ZW-1:0] cz    [N+1];
  side_t                cside [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      cv[0]  <= 1'b0;
    end else if (en) begin
      s1_vld <= din.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      cv[0]  <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a     <= din.chassis_heading[HEAD_W-1] ? HEAD_W'(-din.chassis_heading)
                                                : din.chassis_heading;
      s1_neg   <= din.chassis_heading[HEAD_W-1];
      s1_yprod <= din.yaw_rate * $signed(YAW_MUL);
      s1_sx    <= din.speed_x;
      s1_sy    <= din.speed_y;
      s1_side  <= '{turn: din.speed_turn, spin: din.spin_mode,
                    down: din.ascent_mode & ~din.spin_mode};

      s2_b    <= {7'b0, s1_a} * HEAD_MUL;
      s2_neg  <= s1_neg;
      s2_off  <= EIGHTH_TURN - s1_yprod[31:0];
      s2_sx   <= s1_sx;
      s2_sy   <= s1_sy;
      s2_side <= s1_side;

      s3_hb   <= s2_neg ? (~s3_hab + 32'd1) : s3_hab;
      s3_off  <= s2_off;
      s3_sx   <= s2_sx;
      s3_sy   <= s2_sy;
      s3_side <= s2_side;

      // fold by half a turn flips the top angle bit
      cz[0]    <= $signed({s4_ang[31] ^ s4_fold, s4_ang[31] ^ s4_fold, s4_ang[30:0]});
      cx[0]    <= s4_fold ? -s4_vx : s4_vx;
      cy[0]    <= s4_fold ? -s4_vy : s4_vy;
      cside[0] <= s3_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic [ZW-1:0] ATAN_I = {{(ZW-ATAN_W){1'b0}}, atan_bam(5'(i))};

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed(ATAN_I);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed(ATAN_I);
        end
        cside[i+1] <= cside[i];
      end
    end
  end

  // ---------------- gain correction, split multiply ----------------
  logic               m1_vld;
  logic [47:0]        m1_lo;
  logic signed [48:0] m1_hi;
  side_t              m1_side;

  logic                    m2_vld;
  logic signed [FWD_W-1:0] m2_fwd;
  side_t                   m2_side;
  logic signed [66:0]      m2_p;

  logic               g_vld;
  logic signed [36:0] g_prod;
  logic signed [FWD_W-1:0] g_fwd;
  side_t              g_side;

  always_comb begin
    m2_p = $signed({m1_hi, 18'b0}) + $signed({19'b0, m1_lo})
         + 67'sh2000_0000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      g_vld  <= 1'b0;
    end else if (en) begin
      m1_vld <= cv[N];
      m2_vld <= m1_vld;
      g_vld  <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_lo   <= cy[N][17:0] * INV_GAIN;
      m1_hi   <= $signed(cy[N][VW-1:18]) * $signed({1'b0, INV_GAIN});
      m1_side <= cside[N];

      m2_fwd  <= m2_p[65:46];
      m2_side <= m1_side;

      g_prod  <= m2_fwd * $signed({1'b0, gain});
      g_fwd   <= m2_fwd;
      g_side  <= m2_side;
    end
  end

  // ---------------- rounding, saturation ----------------
  logic signed [36:0] rnd;
  logic signed [28:0] sel;
  out_word_t          res;

  always_comb begin
    rnd = g_prod + 37'sd128;
    sel = g_side.spin ? rnd[36:8] : {{(29-FWD_W){g_fwd[FWD_W-1]}}, g_fwd};
    res.turn_speed = g_side.turn;
    res.down_slope = g_side.down;
    if (!sel[28] && (|sel[27:FWD_W-1])) begin
      res.forward_speed = {1'b0, {(FWD_W-1){1'b1}}};
    end else if (sel[28] && !(&sel[27:FWD_W-1])) begin
      res.forward_speed = {1'b1, {(FWD_W-1){1'b0}}};
    end else begin
      res.forward_speed = sel[FWD_W-1:0];
    end
  end

  // ---------------- two-word output buffer ----------------
  out_word_t o_word;
  out_word_t s_word;

  assign en        = (cnt != 2'd2);
  assign din.ready = en;
  assign push      = en && g_vld;
  assign pop       = dout.valid && dout.ready;

  always_comb begin
    cnt_next = cnt + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      o_word <= s_word;
    end else if (push && (cnt == 2'd0 || pop)) begin
      o_word <= res;
    end
    if (push && !pop && cnt == 2'd1) begin
      s_word <= res;
    end
  end

  assign dout.valid         = (cnt != 2'd0);
  assign dout.forward_speed = o_word.forward_speed;
  assign dout.turn_speed    = o_word.turn_speed;
  assign dout.down_slope    = o_word.down_slope;

`ifndef SYNTH
  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !push)
    else $error("push into full output buffer");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(g_vld) && $stable(cv[N]))
    else $error("pipeline moved while stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop) |=> (cnt == 2'd1) && en)
    else $error("buffer did not drain");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && cnt == 2'd1) |=> !en && dout.valid)
    else $error("buffer full but ready held");
`endif

endmodule
